>>> rtl/mpa_pkg.sv
// Shared types and codes for the scheduler arithmetic engine.
// No dependencies; used only by mlfq_priority_arith.sv in rtl.
`default_nettype none
package mpa_pkg;

  typedef enum logic [2:0] {
    CMD_SET_NICE = 3'd0,
    CMD_LOAD     = 3'd1,
    CMD_RECENT   = 3'd2,
    CMD_PRIO     = 3'd3,
    CMD_READ     = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_PRIO,
    ST_LMUL,
    ST_LSUM,
    ST_WRITE,
    ST_REPORT,
    ST_DONE
  } state_t;

  localparam int NICE_MIN  = -20;
  localparam int NICE_MAX  = 20;
  localparam int READY_MAX = 64;

endpackage
`default_nettype wire

>>> rtl/mlfq_priority_arith.sv
// Top level of the multilevel-feedback scheduler arithmetic engine.
// Uses mpa_pkg, mpa_store (slot memory) and mpa_div (coefficient divider).
//
// Channel | Dir | tdata (low bit first)                                 | tuser
// s_      | in  | slot[5:0], new_nice[11:6], ready_count[18:12]         | command[2:0]
// m_      | out | priority_res, nice_value, recent_cpu_fixed,           | -
//         |     | recent_cpu_x100, load_avg_x100 (6/6/32/32/16 bits)   |
//
// One command at a time. Set nice and recent update wait for the divider,
// which forms the decay coefficient one bit per cycle.
// After reset the slot memory is cleared with s_tready low.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module mlfq_priority_arith #(
  parameter int SLOTS = 64,
  parameter int FRACTION_BITS = 14,
  parameter int PRIORITY_TOP = 63,
  localparam int PW = $clog2(PRIORITY_TOP + 1),
  localparam int OUT_W = ((PW + 86 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [23:0]      s_tdata,   // slot, new_nice, ready_count
  input  wire logic [2:0]       s_tuser,   // command
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata    // priority_res, nice_value, recent_cpu_fixed,
                                           // recent_cpu_x100, load_avg_x100
);
  localparam int AW = $clog2(SLOTS);
  localparam int EW = 32 + 6 + PW;
  localparam logic signed [63:0] FONE = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] LOAD_A = (59 * FONE) / 60;
  localparam logic signed [63:0] LOAD_B = FONE / 60;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  function automatic logic signed [63:0] tdivf(input logic signed [63:0] x);
    if (x < 0) return (x + FONE - 64'sd1) >>> FRACTION_BITS;
    return x >>> FRACTION_BITS;
  endfunction

  function automatic logic signed [63:0] rndf(input logic signed [63:0] x);
    if (x >= 0) return (x + (FONE >>> 1)) >>> FRACTION_BITS;
    return -((-x + (FONE >>> 1)) >>> FRACTION_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > SAT_HI) return 32'sh7fffffff;
    if (x < SAT_LO) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic [AW-1:0] slot_index(input logic [5:0] s);
    logic [15:0] v;
    v = 16'(s);
    for (int k = 5; k >= 0; k--) begin
      if (32'(v) >= (SLOTS << k)) v = v - 16'(SLOTS << k);
    end
    return v[AW-1:0];
  endfunction

  mpa_pkg::state_t state, state_next;

  logic [2:0]                      cmd;
  logic [AW-1:0]                   idx;
  logic signed [5:0]               nice_in;
  logic [6:0]                      ready;
  logic signed [31:0]              rc;
  logic signed [5:0]               nc;
  logic [PW-1:0]                   pc;
  logic signed [31:0]              load;
  logic signed [FRACTION_BITS+32:0] prod;
  logic signed [49:0]              lprod;
  logic signed [39:0]              rx_prod;
  logic signed [39:0]              lx_prod;

  logic                            accept;
  logic                            clearing;
  logic [EW-1:0]                   rd_data;
  logic                            div_start;
  logic                            div_done;
  logic [FRACTION_BITS-1:0]        coef;
  logic signed [5:0]               nice_sat;
  logic [6:0]                      ready_sat;
  logic signed [63:0]              q4;
  logic signed [63:0]              pval;
  logic signed [63:0]              lx;

  assign s_tready = (state == mpa_pkg::ST_IDLE) && !clearing;
  assign accept = s_tvalid && s_tready;

  always_comb begin
    if ($signed(s_tdata[11:6]) < 6'(mpa_pkg::NICE_MIN)) begin
      nice_sat = 6'(mpa_pkg::NICE_MIN);
    end else if ($signed(s_tdata[11:6]) > 6'(mpa_pkg::NICE_MAX)) begin
      nice_sat = 6'(mpa_pkg::NICE_MAX);
    end else begin
      nice_sat = $signed(s_tdata[11:6]);
    end
    ready_sat = (s_tdata[18:12] > 7'(mpa_pkg::READY_MAX)) ? 7'(mpa_pkg::READY_MAX)
                                                           : s_tdata[18:12];
  end

  mpa_store #(.SLOTS(SLOTS), .W(EW)) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (slot_index(s_tdata[5:0])),
    .rd_data  (rd_data),
    .wr_en    (state == mpa_pkg::ST_WRITE),
    .wr_addr  (idx),
    .wr_data  ({rc, nc, pc}),
    .clearing (clearing)
  );

  assign div_start = (state == mpa_pkg::ST_FETCH)
                  && (cmd == mpa_pkg::CMD_SET_NICE || cmd == mpa_pkg::CMD_RECENT);

  mpa_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .two_l ({load, 1'b0}),
    .done  (div_done),
    .coef  (coef)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mpa_pkg::ST_IDLE: begin
        if (accept) state_next = mpa_pkg::ST_FETCH;
      end
      mpa_pkg::ST_FETCH: begin
        case (cmd)
          mpa_pkg::CMD_SET_NICE, mpa_pkg::CMD_RECENT: state_next = mpa_pkg::ST_DIV;
          mpa_pkg::CMD_LOAD: state_next = mpa_pkg::ST_LMUL;
          mpa_pkg::CMD_PRIO: state_next = mpa_pkg::ST_PRIO;
          default: state_next = mpa_pkg::ST_REPORT;
        endcase
      end
      mpa_pkg::ST_DIV: begin
        if (div_done) state_next = mpa_pkg::ST_MUL;
      end
      mpa_pkg::ST_MUL: state_next = mpa_pkg::ST_SUM;
      mpa_pkg::ST_SUM: begin
        state_next = (cmd == mpa_pkg::CMD_SET_NICE) ? mpa_pkg::ST_PRIO : mpa_pkg::ST_WRITE;
      end
      mpa_pkg::ST_PRIO: state_next = mpa_pkg::ST_WRITE;
      mpa_pkg::ST_LMUL: state_next = mpa_pkg::ST_LSUM;
      mpa_pkg::ST_LSUM: state_next = mpa_pkg::ST_REPORT;
      mpa_pkg::ST_WRITE: state_next = mpa_pkg::ST_REPORT;
      mpa_pkg::ST_REPORT: state_next = mpa_pkg::ST_DONE;
      mpa_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = mpa_pkg::ST_IDLE;
      end
      default: state_next = mpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q4 = (rc < 0) ? ((64'(rc) + 64'sd3) >>> 2) : (64'(rc) >>> 2);
    pval = 64'(PRIORITY_TOP) - rndf(q4) - 64'(nc) * 64'sd2;
    lx = rndf(64'(lx_prod));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load <= '0;
    end else if (state == mpa_pkg::ST_LSUM) begin
      load <= sat32(tdivf(64'(lprod)) + LOAD_B * 64'(ready));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= s_tuser;
      idx     <= slot_index(s_tdata[5:0]);
      nice_in <= nice_sat;
      ready   <= ready_sat;
    end
    case (state)
      mpa_pkg::ST_FETCH: begin
        rc <= $signed(rd_data[EW-1 -: 32]);
        nc <= (cmd == mpa_pkg::CMD_SET_NICE) ? nice_in : $signed(rd_data[PW+5:PW]);
        pc <= rd_data[PW-1:0];
      end
      mpa_pkg::ST_MUL: prod <= $signed({1'b0, coef}) * rc;
      mpa_pkg::ST_SUM: rc <= sat32(tdivf(64'(prod)) + (64'(nc) <<< FRACTION_BITS));
      mpa_pkg::ST_PRIO: begin
        if (pval > 64'(PRIORITY_TOP)) pc <= PW'(PRIORITY_TOP);
        else if (pval < 0) pc <= '0;
        else pc <= pval[PW-1:0];
      end
      mpa_pkg::ST_LMUL: lprod <= $signed(18'(LOAD_A)) * load;
      mpa_pkg::ST_REPORT: begin
        rx_prod <= rc * 40'sd100;
        lx_prod <= load * 40'sd100;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == mpa_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mpa_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_W'({(lx > 64'sd65535) ? 16'hffff : (lx < 0) ? 16'h0000 : lx[15:0],
                         sat32(rndf(64'(rx_prod))), rc, nc, pc});
    end
  end

  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == mpa_pkg::ST_FETCH) else $error("accepted item not fetched");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("input ready during memory clear");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == mpa_pkg::ST_DIV) else $error("divider finished outside wait");
  a_prio_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[PW-1:0] <= PW'(PRIORITY_TOP)) else $error("priority out of range");

endmodule
`default_nettype wire

>>> rtl/mpa_store.sv
// Per-slot state memory holding recent cpu, nice and priority.
// Clears itself after reset, one entry a cycle; no package dependency.
`default_nettype none
module mpa_store #(
  parameter int SLOTS = 64,
  parameter int W = 44
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic      [W-1:0]             rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
  input  wire logic [W-1:0]             wr_data,
  output logic                          clearing
);
  localparam int AW = $clog2(SLOTS);

  logic [W-1:0]  mem [SLOTS];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/mpa_div.sv
// Restoring divider for the recent-cpu decay coefficient 2L*F/(2L+F).
// One quotient bit a cycle; no package dependency.
`default_nettype none
module mpa_div #(
  parameter int FRACTION_BITS = 14
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [32:0]              two_l,
  output logic                          done,
  output logic [FRACTION_BITS-1:0]      coef
);
  localparam int CW = $clog2(FRACTION_BITS + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [33:0]   rem;
  logic [33:0]   den;
  logic [34:0]   rem2;

  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(FRACTION_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, two_l};
      den  <= {1'b0, two_l} + (34'd1 << FRACTION_BITS);
      coef <= '0;
    end else if (busy) begin
      if (rem2 >= {1'b0, den}) begin
        rem  <= 34'(rem2 - {1'b0, den});
        coef <= {coef[FRACTION_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem2[33:0];
        coef <= {coef[FRACTION_BITS-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire
